// File: hdl/jdpq_pkg.sv
// Shared definitions for the joystick direction and press qualifier.
// Widths, register map, reset values and direction codes.
// No dependencies.
package jdpq_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 32;
    localparam int MS_BITS     = 16;
    localparam int DIR_BITS    = 3;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELD_W = 2 * SAMPLE_BITS + 1 + TIME_BITS;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = DIR_BITS + 2;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int NUM_REGS   = 6;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [TIME_BITS-1:0]   ms_time_t;
    typedef logic [MS_BITS-1:0]     ms_span_t;

    // Register indexes, byte address is 4 * index
    typedef enum logic [REG_IDX_W-1:0] {
        REG_AXIS_MAX      = 3'd0,
        REG_DEAD_LOW      = 3'd1,
        REG_DEAD_HIGH     = 3'd2,
        REG_REPEAT_MS     = 3'd3,
        REG_DEBOUNCE_MS   = 3'd4,
        REG_LONG_PRESS_MS = 3'd5
    } cfg_reg_e;

    // Reset values
    localparam sample_t  AXIS_MAX_RST      = sample_t'(1023);
    localparam sample_t  DEAD_LOW_RST      = sample_t'(300);
    localparam sample_t  DEAD_HIGH_RST     = sample_t'(700);
    localparam ms_span_t REPEAT_MS_RST     = ms_span_t'(300);
    localparam ms_span_t DEBOUNCE_MS_RST   = ms_span_t'(50);
    localparam ms_span_t LONG_PRESS_MS_RST = ms_span_t'(1000);

    // Direction codes
    typedef enum logic [DIR_BITS-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_UP    = 3'd4
    } dir_t;

endpackage

// File: hdl/joystick_direction_and_press_qualifier_top.sv
// Joystick direction and press qualifier: one poll in, one qualified result out.
// Input register, single-pass qualify logic, output register; APB register file.
// Depends on jdpq_pkg.
//
//  Channel   Ports              Payload (low bit up)
//  --------  -----------------  -------------------------------------------------
//  poll in   s_tvalid/s_tready  x_sample[9:0] y_sample[19:10] button_level[20]
//                               now_ms[52:21], zero pad to 56 bits
//  result    m_tvalid/m_tready  direction[2:0] pressed[3] long_pressed[4], pad to 8
//  config    APB psel/penable   regs at 4*i: axis_max dead_low dead_high
//                               repeat_ms debounce_ms long_press_ms
//
// One poll per cycle sustained while m_tready stays high. The timing state is read
// and written in the single qualify stage, so polls that follow each other in
// consecutive cycles see each other's updates. A stalled result holds the qualify
// stage; the input register still takes one more poll. Synchronous active-low
// reset clears timestamps, button state and config registers to their defaults.
module joystick_direction_and_press_qualifier_top
    import jdpq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // poll input: x_sample, y_sample, button_level, now_ms
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    // result: direction, pressed, long_pressed
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------
    sample_t  axis_max_reg, dead_low_reg, dead_high_reg;
    ms_span_t repeat_ms_reg, debounce_ms_reg, long_press_ms_reg;
    logic     cfg_wr;
    cfg_reg_e cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_max_reg      <= AXIS_MAX_RST;
            dead_low_reg      <= DEAD_LOW_RST;
            dead_high_reg     <= DEAD_HIGH_RST;
            repeat_ms_reg     <= REPEAT_MS_RST;
            debounce_ms_reg   <= DEBOUNCE_MS_RST;
            long_press_ms_reg <= LONG_PRESS_MS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_AXIS_MAX:      axis_max_reg      <= pwdata[SAMPLE_BITS-1:0];
                REG_DEAD_LOW:      dead_low_reg      <= pwdata[SAMPLE_BITS-1:0];
                REG_DEAD_HIGH:     dead_high_reg     <= pwdata[SAMPLE_BITS-1:0];
                REG_REPEAT_MS:     repeat_ms_reg     <= pwdata[MS_BITS-1:0];
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= pwdata[MS_BITS-1:0];
                REG_LONG_PRESS_MS: long_press_ms_reg <= pwdata[MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (cfg_idx)
            REG_AXIS_MAX:      prdata = APB_DATA_W'(axis_max_reg);
            REG_DEAD_LOW:      prdata = APB_DATA_W'(dead_low_reg);
            REG_DEAD_HIGH:     prdata = APB_DATA_W'(dead_high_reg);
            REG_REPEAT_MS:     prdata = APB_DATA_W'(repeat_ms_reg);
            REG_DEBOUNCE_MS:   prdata = APB_DATA_W'(debounce_ms_reg);
            REG_LONG_PRESS_MS: prdata = APB_DATA_W'(long_press_ms_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds the output register
    // ---------------------------------------------------------------
    logic     in_valid_reg, out_valid_reg;
    logic     advance;
    sample_t  x_reg, y_reg;
    logic     btn_reg;
    ms_time_t now_reg;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Poll payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg   <= s_tdata[SAMPLE_BITS-1:0];
            y_reg   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            btn_reg <= s_tdata[2*SAMPLE_BITS];
            now_reg <= s_tdata[2*SAMPLE_BITS+TIME_BITS:2*SAMPLE_BITS+1];
        end
    end

    // ---------------------------------------------------------------
    // Qualify stage
    // ---------------------------------------------------------------
    ms_time_t last_event_reg, last_event_next;
    ms_time_t last_long_reg, last_long_next;
    logic     prev_button_reg, pressed_reg, pressed_next;
    logic     held;
    logic signed [SAMPLE_BITS:0] y_inv, lo_s, hi_s;
    logic     x_lt, x_gt, y_lt, y_gt, outside, moved, refreshed;
    ms_time_t since_event, since_long, settle;
    logic     long_next;
    dir_t     dir_next;

    assign held  = ~btn_reg;
    assign y_inv = $signed({1'b0, axis_max_reg}) - $signed({1'b0, y_reg});
    assign lo_s  = $signed({1'b0, dead_low_reg});
    assign hi_s  = $signed({1'b0, dead_high_reg});

    // Dead-band tests
    assign x_lt    = x_reg < dead_low_reg;
    assign x_gt    = x_reg > dead_high_reg;
    assign y_lt    = y_inv < lo_s;
    assign y_gt    = y_inv > hi_s;
    assign outside = x_lt | x_gt | y_lt | y_gt;

    // Movement gate against the shared timestamp
    assign since_event = now_reg - last_event_reg;
    assign moved       = outside & (since_event > TIME_BITS'(repeat_ms_reg));

    // Later test overrides earlier: left, right, down, up
    always_comb begin
        dir_next = DIR_NONE;
        if (moved) begin
            priority if (y_gt) dir_next = DIR_UP;
            else if (y_lt)     dir_next = DIR_DOWN;
            else if (x_gt)     dir_next = DIR_RIGHT;
            else if (x_lt)     dir_next = DIR_LEFT;
            else               dir_next = DIR_NONE;
        end
    end

    // Either a move or a button edge restarts the shared timestamp
    assign refreshed       = moved | (held != prev_button_reg);
    assign last_event_next = refreshed ? now_reg : last_event_reg;
    assign settle          = refreshed ? '0 : since_event;

    assign pressed_next = (settle > TIME_BITS'(debounce_ms_reg)) ? held : pressed_reg;

    // Long-press repeat
    assign since_long     = now_reg - last_long_reg;
    assign long_next      = held & (settle > TIME_BITS'(long_press_ms_reg))
                            & (since_long >= TIME_BITS'(long_press_ms_reg));
    assign last_long_next = long_next ? now_reg : last_long_reg;

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_event_reg  <= '0;
            last_long_reg   <= '0;
            prev_button_reg <= 1'b0;
            pressed_reg     <= 1'b0;
        end else if (advance) begin
            last_event_reg  <= last_event_next;
            last_long_reg   <= last_long_next;
            prev_button_reg <= held;
            pressed_reg     <= pressed_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    dir_t dir_reg;
    logic long_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dir_reg  <= dir_next;
            long_reg <= long_next;
        end
    end

    assign m_tdata = M_DATA_W'({long_reg, pressed_reg, dir_reg});

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but s_tready low");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(last_event_reg) && $stable(last_long_reg)
                                     && $stable(pressed_reg)))
        else $error("timing state changed while result stalled");

    a_move_stamps: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dir_next != DIR_NONE) |=> (last_event_reg == $past(now_reg)))
        else $error("reported direction did not refresh event timestamp");

    a_long_needs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && long_next) |=> (prev_button_reg && last_long_reg == $past(now_reg)))
        else $error("long press pulse without held button or timestamp");

endmodule

// File: tb/joystick_direction_and_press_qualifier_top_tb.sv
`timescale 1ns / 100ps
// Testbench for joystick_direction_and_press_qualifier_top: directed polls and register
// writes, then random phases; checked against table values or an in-bench poll qualifier.
// Depends on jdpq_pkg and the top-level RTL.
module joystick_direction_and_press_qualifier_top_tb;
    import jdpq_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_POLLS  = 80;

    typedef struct {
        sample_t  x;
        sample_t  y;
        logic     btn;
        ms_time_t now;
    } poll_t;

    typedef struct {
        dir_t dir;
        logic pressed;
        logic long_p;
    } result_t;

    typedef enum { ROW_POLL, ROW_CFG } row_kind_e;

    typedef struct {
        row_kind_e   kind;
        int unsigned reg_idx;
        logic [31:0] wdata;
        poll_t       poll;
        bit          typed;
        result_t     want;
    } row_t;

    // DUT ports
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Qualifier model: configuration copy and timing state
    sample_t  cfg_axis_max  = AXIS_MAX_RST;
    sample_t  cfg_dead_low  = DEAD_LOW_RST;
    sample_t  cfg_dead_high = DEAD_HIGH_RST;
    ms_span_t cfg_repeat    = REPEAT_MS_RST;
    ms_span_t cfg_debounce  = DEBOUNCE_MS_RST;
    ms_span_t cfg_long      = LONG_PRESS_MS_RST;
    ms_time_t shared_stamp  = '0;
    ms_time_t pulse_stamp   = '0;
    logic     btn_was_held  = 1'b0;
    logic     btn_pressed   = 1'b0;

    result_t  result_q[$];
    int       errors      = 0;
    int       idle_cycles = 0;
    int       sink_hold   = 0;
    bit       burst       = 1'b0;

    joystick_direction_and_press_qualifier_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Wrapping millisecond difference
    function automatic ms_time_t since(ms_time_t now, ms_time_t then);
        return now - then;
    endfunction

    // One poll through the qualifier: direction, debounce, long-press pulse
    function automatic result_t qualify_poll(poll_t p);
        int      x_pos, y_raw, y_pos, lo, hi;
        logic    held;
        bit      centered;
        result_t r;
        x_pos = p.x;
        y_raw = p.y;
        y_pos = int'(cfg_axis_max) - y_raw;   // may go negative
        lo    = cfg_dead_low;
        hi    = cfg_dead_high;
        held  = ~p.btn;
        centered = x_pos >= lo && x_pos <= hi && y_pos >= lo && y_pos <= hi;
        r.dir = DIR_NONE;
        r.long_p = 1'b0;
        // later tests win: left, right, down, up
        if (!centered && since(p.now, shared_stamp) > cfg_repeat) begin
            shared_stamp = p.now;
            if (x_pos < lo) r.dir = DIR_LEFT;
            if (x_pos > hi) r.dir = DIR_RIGHT;
            if (y_pos < lo) r.dir = DIR_DOWN;
            if (y_pos > hi) r.dir = DIR_UP;
        end
        // debounce shares the movement stamp
        if (held != btn_was_held) shared_stamp = p.now;
        if (since(p.now, shared_stamp) > cfg_debounce) btn_pressed = held;
        btn_was_held = held;
        if (held && since(p.now, shared_stamp) > cfg_long &&
            since(p.now, pulse_stamp) >= cfg_long) begin
            r.long_p = 1'b1;
            pulse_stamp = p.now;
        end
        r.pressed = btn_pressed;
        return r;
    endfunction

    function automatic row_t poll_row(int x, int y, bit btn, ms_time_t now);
        row_t r;
        r.kind         = ROW_POLL;
        r.reg_idx      = 0;
        r.wdata        = '0;
        r.poll.x       = sample_t'(x);
        r.poll.y       = sample_t'(y);
        r.poll.btn     = btn;
        r.poll.now     = now;
        r.typed        = 1'b0;
        r.want.dir     = DIR_NONE;
        r.want.pressed = 1'b0;
        r.want.long_p  = 1'b0;
        return r;
    endfunction

    function automatic row_t typed_row(int x, int y, bit btn, ms_time_t now,
                                       dir_t dir, bit pressed, bit long_p);
        row_t r;
        r = poll_row(x, y, btn, now);
        r.typed        = 1'b1;
        r.want.dir     = dir;
        r.want.pressed = pressed;
        r.want.long_p  = long_p;
        return r;
    endfunction

    function automatic row_t reg_row(int unsigned idx, logic [31:0] value);
        row_t r;
        r = poll_row(0, 0, 1'b1, '0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.wdata   = value;
        return r;
    endfunction

    // Wait until every result is back, plus the pipeline latency
    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access phase, then the bus returns to idle; model copy follows
    task automatic apb_write(int unsigned idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_AXIS_MAX:      cfg_axis_max  = value[SAMPLE_BITS-1:0];
            REG_DEAD_LOW:      cfg_dead_low  = value[SAMPLE_BITS-1:0];
            REG_DEAD_HIGH:     cfg_dead_high = value[SAMPLE_BITS-1:0];
            REG_REPEAT_MS:     cfg_repeat    = value[MS_BITS-1:0];
            REG_DEBOUNCE_MS:   cfg_debounce  = value[MS_BITS-1:0];
            REG_LONG_PRESS_MS: cfg_long      = value[MS_BITS-1:0];
            default: ;  // unmapped address
        endcase
    endtask

    // Present one poll, hold it until the transaction, then record its result
    task automatic send_poll(poll_t p, bit typed, result_t want);
        int      gap;
        result_t model_r;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({p.now, p.btn, p.y, p.x});
        do @(posedge aclk); while (!s_tready);
        model_r = qualify_poll(p);
        result_q.push_back(typed ? want : model_r);
    endtask

    // Result side: check each transaction, then, outside bursts, stall for a random count
    always @(posedge aclk) begin : result_sink
        result_t want;
        dir_t    got_dir;
        logic    got_pr, got_lp;
        int      w;
        if (m_tvalid && m_tready) begin
            got_dir = dir_t'(m_tdata[DIR_BITS-1:0]);
            got_pr  = m_tdata[DIR_BITS];
            got_lp  = m_tdata[DIR_BITS+1];
            if (result_q.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (got_dir !== want.dir) begin
                    $display("%0t: direction expected %0d actual %0d",
                             $time, want.dir, got_dir);
                    errors++;
                end
                if (got_pr !== want.pressed) begin
                    $display("%0t: pressed expected %0b actual %0b",
                             $time, want.pressed, got_pr);
                    errors++;
                end
                if (got_lp !== want.long_p) begin
                    $display("%0t: long_pressed expected %0b actual %0b",
                             $time, want.long_p, got_lp);
                    errors++;
                end
            end
            w = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (w > 0) begin
                m_tready  <= 1'b0;
                sink_hold <= w;
            end
        end else if (!m_tready) begin
            if (sink_hold <= 1) m_tready <= 1'b1;
            sink_hold <= sink_hold - 1;
        end
    end

    // Watchdog: cycles without any transaction on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        row_t        plan[$];
        poll_t       p;
        result_t     no_result;
        int unsigned vals[NUM_REGS];
        int          run_left, sel, span, step_max;
        logic        level;

        no_result.dir     = DIR_NONE;
        no_result.pressed = 1'b0;
        no_result.long_p  = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset configuration first
        plan.push_back(typed_row(512, 512, 1'b1, 32'd0, DIR_NONE, 0, 0));
        plan.push_back(typed_row(0, 512, 1'b1, 32'd301, DIR_LEFT, 0, 0));
        // inside repeat spacing
        plan.push_back(typed_row(1023, 512, 1'b1, 32'd400, DIR_NONE, 0, 0));
        plan.push_back(typed_row(1023, 512, 1'b1, 32'd700, DIR_RIGHT, 0, 0));
        plan.push_back(typed_row(512, 0, 1'b1, 32'd1100, DIR_UP, 0, 0));
        plan.push_back(typed_row(512, 1023, 1'b1, 32'd1500, DIR_DOWN, 0, 0));
        // two axes out: up wins over left
        plan.push_back(typed_row(0, 0, 1'b1, 32'd1900, DIR_UP, 0, 0));
        // press, debounce, long-press pulses
        plan.push_back(typed_row(512, 512, 1'b0, 32'd2000, DIR_NONE, 0, 0));
        plan.push_back(typed_row(512, 512, 1'b0, 32'd2051, DIR_NONE, 1, 0));
        plan.push_back(typed_row(512, 512, 1'b0, 32'd3001, DIR_NONE, 1, 1));
        plan.push_back(typed_row(512, 512, 1'b0, 32'd3500, DIR_NONE, 1, 0));
        plan.push_back(typed_row(512, 512, 1'b0, 32'd4001, DIR_NONE, 1, 1));
        // movement while held restarts the button timing
        plan.push_back(typed_row(0, 512, 1'b0, 32'd4400, DIR_LEFT, 1, 0));
        plan.push_back(typed_row(512, 512, 1'b1, 32'd4420, DIR_NONE, 1, 0));
        plan.push_back(typed_row(512, 512, 1'b1, 32'd4500, DIR_NONE, 0, 0));
        // timestamp wrap
        plan.push_back(typed_row(0, 512, 1'b1, 32'hFFFF_FFF0, DIR_LEFT, 0, 0));
        plan.push_back(typed_row(0, 512, 1'b1, 32'h0000_0100, DIR_NONE, 0, 0));
        plan.push_back(typed_row(0, 512, 1'b1, 32'h0000_0200, DIR_LEFT, 0, 0));
        // oversized write is masked; y above full scale inverts negative
        plan.push_back(reg_row(REG_AXIS_MAX, 32'hFFFF_FC00 | 32'd600));
        plan.push_back(poll_row(512, 900, 1'b1, 32'h0000_1000));
        // writes past the register map are ignored
        plan.push_back(reg_row(NUM_REGS, 32'h0000_0000));
        plan.push_back(reg_row(NUM_REGS + 1, 32'hFFFF_FFFF));
        // inverted dead band
        plan.push_back(reg_row(REG_DEAD_LOW, 32'd800));
        plan.push_back(reg_row(REG_DEAD_HIGH, 32'd200));
        plan.push_back(poll_row(512, 512, 1'b1, 32'h0000_2000));
        plan.push_back(poll_row(1023, 0, 1'b0, 32'h0000_2400));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                apb_write(plan[i].reg_idx, plan[i].wdata);
            end else begin
                send_poll(plan[i].poll, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: reset values, both extremes, then random settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    vals[REG_AXIS_MAX]      = AXIS_MAX_RST;
                    vals[REG_DEAD_LOW]      = DEAD_LOW_RST;
                    vals[REG_DEAD_HIGH]     = DEAD_HIGH_RST;
                    vals[REG_REPEAT_MS]     = REPEAT_MS_RST;
                    vals[REG_DEBOUNCE_MS]   = DEBOUNCE_MS_RST;
                    vals[REG_LONG_PRESS_MS] = LONG_PRESS_MS_RST;
                end
                1: begin
                    vals[REG_AXIS_MAX]      = 1023;
                    vals[REG_DEAD_LOW]      = 0;
                    vals[REG_DEAD_HIGH]     = 1023;
                    vals[REG_REPEAT_MS]     = 65535;
                    vals[REG_DEBOUNCE_MS]   = 65535;
                    vals[REG_LONG_PRESS_MS] = 65535;
                end
                2: begin
                    foreach (vals[r]) vals[r] = 0;
                end
                default: begin
                    vals[REG_AXIS_MAX]      = $urandom_range(0, 1023);
                    vals[REG_DEAD_LOW]      = $urandom_range(0, 600);
                    vals[REG_DEAD_HIGH]     = $urandom_range(300, 1023);
                    vals[REG_REPEAT_MS]     = $urandom_range(0, 400);
                    vals[REG_DEBOUNCE_MS]   = $urandom_range(0, 400);
                    vals[REG_LONG_PRESS_MS] = $urandom_range(0, 400);
                    if (ph == RAND_PHASES - 1) vals[REG_LONG_PRESS_MS] = $urandom_range(0, 65535);
                end
            endcase
            // junk above bit 15 must be dropped by the register file
            for (int r = 0; r < NUM_REGS; r++) apb_write(r, ($urandom << 16) | vals[r]);

            span = cfg_repeat;
            if (cfg_debounce > span) span = cfg_debounce;
            if (cfg_long > span) span = cfg_long;
            step_max = span / 2 + 2;
            p.now = (ph % 2) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * span + 100) : $urandom;
            level = 1'b1;
            run_left = 0;

            for (int i = 0; i < PHASE_POLLS; i++) begin
                if (i % 16 == 0) burst = ($urandom_range(0, 3) == 0);
                // button held or released in runs, with occasional bounce
                if (run_left == 0) begin
                    level = ~level;
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                p.btn = ($urandom_range(0, 9) == 0) ? ~level : level;
                // mostly centered stick, some full deflections, some noise
                sel = $urandom_range(0, 9);
                if (sel < 9) begin
                    p.x = sample_t'($urandom_range(cfg_dead_low, cfg_dead_high));
                    p.y = cfg_axis_max - sample_t'($urandom_range(cfg_dead_low, cfg_dead_high));
                    if (sel >= 6) begin
                        case ($urandom_range(0, 3))
                            0: p.x = '0;
                            1: p.x = '1;
                            2: p.y = '0;
                            default: p.y = '1;
                        endcase
                    end
                end else begin
                    p.x = sample_t'($urandom);
                    p.y = sample_t'($urandom);
                end
                if ($urandom_range(0, 19) == 0) p.now = $urandom;
                else p.now = p.now + $urandom_range(0, step_max);
                send_poll(p, 1'b0, no_result);
            end
        end
        burst = 1'b0;

        settle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
